/* rtl/bcpg_pkg.sv */
// Package with shared types and constants of the background cell pixel generator.
package bcpg_pkg;

  localparam int unsigned CellColumnsDef = 32;
  localparam int unsigned CellRowsDef    = 16;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 4;
  localparam int unsigned ColourW   = 4;

  // Configuration register indexes.
  typedef enum logic [CfgIndexW-1:0] {
    REG_DISPLAY_MODE   = 3'd0,
    REG_INVERT_COLUMNS = 3'd1,
    REG_INVERT_ROWS    = 3'd2,
    REG_SPLIT_COLUMN   = 3'd3,
    REG_SPLIT_ROW      = 3'd4,
    REG_GRAPHICS_FORE  = 3'd5,
    REG_GRAPHICS_BACK  = 3'd6,
    REG_BACK_COLOUR    = 3'd7
  } reg_index_e;

  // Display modes.
  typedef enum logic [1:0] {
    MODE_NONE_A = 2'd0,
    MODE_SEMI   = 2'd1,
    MODE_NONE_B = 2'd2,
    MODE_BLOCK  = 2'd3
  } display_mode_e;

  typedef struct packed {
    display_mode_e        display_mode;
    logic                 invert_columns;
    logic                 invert_rows;
    logic [3:0]           split_column;
    logic [3:0]           split_row;
    logic [ColourW-1:0]   graphics_fore;
    logic [ColourW-1:0]   graphics_back;
    logic [ColourW-1:0]   back_colour;
  } cfg_t;

endpackage

/* rtl/background_cell_pixel_generator.sv */
// Top level of the background cell pixel generator: name table, pipeline and config.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+--------------------------------------
//   in      | input     | in_valid_i / in_stall_o | req_type, cell_address, cell_byte,
//           |           |                        | pixel_x, pixel_y
//   out     | output    | out_valid_o/out_stall_i | pixel_colour
//   cfg     | input     | cfg_wr_en_i            | cfg_index_i, cfg_data_i
//
// One transfer can be taken on the input in every cycle that it is not
// stalled. A name table write lands in the memory at the edge of its
// transfer. A pixel query reads the name table at its transfer edge into a
// registered read stage, and its colour reaches the output register when the
// read stage moves on. Reset clears the configuration registers and the valid
// bits; the name table has no reset and must be written before it is read. A
// stalled output holds its result, and the input stalls only when the read
// stage is also full and cannot move on.
module background_cell_pixel_generator
  import bcpg_pkg::*;
#(
  parameter int unsigned CellColumns = CellColumnsDef,
  parameter int unsigned CellRows    = CellRowsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [8:0]           cell_address_i,
  input  logic [7:0]           cell_byte_i,
  input  logic [7:0]           pixel_x_i,
  input  logic [7:0]           pixel_y_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ColourW-1:0]   pixel_colour_o,

  input  logic                 cfg_wr_en_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned TableSize = CellColumns * CellRows;
  localparam int unsigned TableAw   = (TableSize > 1) ? $clog2(TableSize) : 1;

  // Configuration registers.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr_en_i) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_DISPLAY_MODE:   cfg_q.display_mode   <= display_mode_e'(cfg_data_i[1:0]);
        REG_INVERT_COLUMNS: cfg_q.invert_columns <= cfg_data_i[0];
        REG_INVERT_ROWS:    cfg_q.invert_rows    <= cfg_data_i[0];
        REG_SPLIT_COLUMN:   cfg_q.split_column   <= cfg_data_i;
        REG_SPLIT_ROW:      cfg_q.split_row      <= cfg_data_i;
        REG_GRAPHICS_FORE:  cfg_q.graphics_fore  <= cfg_data_i;
        REG_GRAPHICS_BACK:  cfg_q.graphics_back  <= cfg_data_i;
        REG_BACK_COLOUR:    cfg_q.back_colour    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Flow control: the output register frees when empty or taken, and the
  // read stage moves on when empty or when the output register frees.
  logic out_valid_q;
  logic rd_valid_q;
  logic out_adv;
  logic rd_adv;
  logic in_xfer;
  logic query_xfer;
  logic write_xfer;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign rd_adv     = !rd_valid_q || out_adv;
  assign in_stall_o = !rd_adv;
  assign in_xfer    = in_valid_i && rd_adv;
  assign query_xfer = in_xfer && req_type_i;
  assign write_xfer = in_xfer && !req_type_i;

  // Name table addressing. Writes beyond the table are dropped. A query off
  // the grid still reads some entry, but its byte is not used.
  logic [31:0]        wr_addr_wide;
  logic [31:0]        rd_addr_wide;
  logic               wr_in_range;
  logic [TableAw-1:0] wr_idx;
  logic [TableAw-1:0] rd_idx;

  assign wr_addr_wide = 32'(cell_address_i);
  assign wr_in_range  = wr_addr_wide < 32'(TableSize);
  assign wr_idx       = wr_addr_wide[TableAw-1:0];
  assign rd_addr_wide = 32'(pixel_y_i[7:4]) * 32'(CellColumns) + 32'(pixel_x_i[7:3]);
  assign rd_idx       = rd_addr_wide[TableAw-1:0];

  logic [7:0] name_table_q [TableSize];
  logic [7:0] rd_byte_q;

  always_ff @(posedge clk_i) begin
    if (write_xfer && wr_in_range) begin
      name_table_q[wr_idx] <= cell_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_xfer) begin
      rd_byte_q <= name_table_q[rd_idx];
    end
  end

  // Read stage: pixel coordinates travel alongside the table read.
  logic [7:0] rd_pixel_x_q;
  logic [7:0] rd_pixel_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (rd_adv) begin
      rd_valid_q <= query_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_xfer) begin
      rd_pixel_x_q <= pixel_x_i;
      rd_pixel_y_q <= pixel_y_i;
    end
  end

  // Colour decision between the read stage and the output register.
  logic [ColourW-1:0] colour_d;
  logic [ColourW-1:0] colour_q;

  bcpg_colour #(
    .CellColumns (CellColumns),
    .CellRows    (CellRows)
  ) u_colour (
    .cfg_i          (cfg_q),
    .pixel_x_i      (rd_pixel_x_q),
    .pixel_y_i      (rd_pixel_y_q),
    .cell_byte_i    (rd_byte_q),
    .pixel_colour_o (colour_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= rd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && rd_valid_q) begin
      colour_q <= colour_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_colour_o = colour_q;

endmodule

/* rtl/bcpg_colour.sv */
// Colour decision for one queried pixel from its cell byte and the configuration.
module bcpg_colour
  import bcpg_pkg::*;
#(
  parameter int unsigned CellColumns = CellColumnsDef,
  parameter int unsigned CellRows    = CellRowsDef
) (
  input  cfg_t               cfg_i,
  input  logic [7:0]         pixel_x_i,
  input  logic [7:0]         pixel_y_i,
  input  logic [7:0]         cell_byte_i,
  output logic [ColourW-1:0] pixel_colour_o
);

  logic [4:0] cell_col;
  logic [3:0] cell_row;
  logic       off_grid;
  logic       text_x;
  logic       text_y;
  logic [2:0] quadrant;

  assign cell_col = pixel_x_i[7:3];
  assign cell_row = pixel_y_i[7:4];
  assign off_grid = (32'(cell_col) >= 32'(CellColumns)) || (32'(cell_row) >= 32'(CellRows));
  assign text_x   = (cell_col < {cfg_i.split_column, 1'b0}) != cfg_i.invert_columns;
  assign text_y   = (cell_row < cfg_i.split_row) != cfg_i.invert_rows;
  // Quadrant row from pixel row bits 3:2, quadrant column from pixel column bit 2.
  // The cell byte bit is 7 minus the quadrant number, which is its inverse.
  assign quadrant = {pixel_y_i[3:2], pixel_x_i[2]};

  always_comb begin
    pixel_colour_o = cfg_i.back_colour;
    if (!off_grid && !(text_x && text_y)) begin
      unique case (cfg_i.display_mode)
        MODE_SEMI: begin
          pixel_colour_o = cell_byte_i[~quadrant] ? cfg_i.graphics_fore : cfg_i.graphics_back;
        end
        MODE_BLOCK: begin
          pixel_colour_o = pixel_y_i[3] ? cell_byte_i[3:0] : cell_byte_i[7:4];
        end
        MODE_NONE_A, MODE_NONE_B: begin
          pixel_colour_o = cfg_i.back_colour;
        end
        default: begin
          pixel_colour_o = cfg_i.back_colour;
        end
      endcase
    end
  end

endmodule
